// ===== rtl/core/pcdm_pkg.sv =====
// pcdm_pkg: shared types and fixed constants for the PWM capture duty meter.
// No dependencies; imported by every module of the block except pcdm_checker.
package pcdm_pkg;

  // Fixed port field widths
  localparam int STAMP_W  = 16;
  localparam int DUR_W    = 16;
  localparam int TOTAL_W  = 17;
  localparam int DUTY_W   = 7;

  // Duty scale and the quotient width it implies (high <= total, so duty <= 100 < 128)
  localparam int DUTY_SCALE = 100;
  localparam int QUOT_BITS  = DUTY_W;
  localparam int CNT_W      = $clog2(QUOT_BITS);

  // Depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Polarity flags carried with each request
  typedef struct packed {
    logic was_falling;
    logic next_falling;
  } pcdm_flags_t;

endpackage

// ===== rtl/core/pcdm_front.sv =====
// pcdm_front: accepts edge requests, tracks expected polarity and last timestamp,
// and produces the updated high/low durations. Depends on pcdm_pkg.
module pcdm_front #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,
  input  logic                        accept,
  input  logic [pcdm_pkg::STAMP_W-1:0] stamp_in,
  output logic [TIMER_WIDTH-1:0]      high_nxt,
  output logic [TIMER_WIDTH-1:0]      low_nxt,
  output pcdm_pkg::pcdm_flags_t       flags
);
  import pcdm_pkg::*;

  logic                   expect_falling_r;
  logic [TIMER_WIDTH-1:0] prev_stamp_r;
  logic [TIMER_WIDTH-1:0] high_r;
  logic [TIMER_WIDTH-1:0] low_r;
  logic [TIMER_WIDTH-1:0] stamp;
  logic [TIMER_WIDTH-1:0] elapsed;

  assign stamp   = TIMER_WIDTH'(stamp_in);
  assign elapsed = stamp - prev_stamp_r;

  always_comb begin
    high_nxt = high_r;
    low_nxt  = low_r;
    if (expect_falling_r) begin
      high_nxt = elapsed;
    end else begin
      low_nxt = elapsed;
    end
  end

  assign flags.was_falling  = expect_falling_r;
  assign flags.next_falling = ~expect_falling_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expect_falling_r <= 1'b0;
      prev_stamp_r     <= '0;
      high_r           <= '0;
      low_r            <= '0;
    end else if (cfg_wr_en) begin
      // re-arm polarity; durations and timestamp are kept
      expect_falling_r <= cfg_wr_data;
    end else if (accept) begin
      expect_falling_r <= ~expect_falling_r;
      prev_stamp_r     <= stamp;
      high_r           <= high_nxt;
      low_r            <= low_nxt;
    end
  end

endmodule

// ===== rtl/core/pcdm_queue.sv =====
// pcdm_queue: small register FIFO that decouples the front from the back.
// Depends on pcdm_pkg for its depth.
module pcdm_queue #(
  parameter int WIDTH = 34
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);
  import pcdm_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_QW = $clog2(QUEUE_DEPTH + 1);

  logic [WIDTH-1:0]  mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wptr_r;
  logic [PTR_W-1:0]  rptr_r;
  logic [CNT_QW-1:0] count_r;

  assign full      = (count_r == CNT_QW'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rptr_r];

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wptr_r <= ptr_inc(wptr_r);
      end
      if (pop) begin
        rptr_r <= ptr_inc(rptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/pcdm_back.sv =====
// pcdm_back: takes queued durations, forms the period and the duty percent with a
// restoring divider (one quotient bit a cycle), and holds the result. Depends on pcdm_pkg.
module pcdm_back #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           q_not_empty,
  input  logic [TIMER_WIDTH-1:0]         q_high,
  input  logic [TIMER_WIDTH-1:0]         q_low,
  input  pcdm_pkg::pcdm_flags_t          q_flags,
  output logic                           q_pop,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [pcdm_pkg::DUR_W-1:0]     out_high_time,
  output logic [pcdm_pkg::DUR_W-1:0]     out_low_time,
  output logic [pcdm_pkg::TOTAL_W-1:0]   out_total_period,
  output logic [pcdm_pkg::DUTY_W-1:0]    out_duty_percent,
  output logic                           out_duty_valid,
  output logic                           out_edge_was_falling,
  output logic                           out_next_edge_falling
);
  import pcdm_pkg::*;

  localparam int SUM_W = TIMER_WIDTH + 1;
  localparam int DIV_W = TIMER_WIDTH + QUOT_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_OUT  = 2'd2;

  logic [1:0]             state_r;
  logic [1:0]             state_nxt;
  logic [CNT_W-1:0]       cnt_r;
  logic [DIV_W-1:0]       rem_r;
  logic [QUOT_BITS-1:0]   quot_r;
  logic [TIMER_WIDTH-1:0] high_r;
  logic [TIMER_WIDTH-1:0] low_r;
  logic [SUM_W-1:0]       total_r;
  pcdm_flags_t            flags_r;

  logic [DIV_W-1:0]       divisor_sh;
  logic                   fits;

  assign divisor_sh = DIV_W'(total_r) << cnt_r;
  assign fits       = (rem_r >= divisor_sh);
  assign q_pop      = (state_r == ST_IDLE) && q_not_empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_not_empty) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == '0) state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      high_r  <= q_high;
      low_r   <= q_low;
      flags_r <= q_flags;
      total_r <= SUM_W'(q_high) + SUM_W'(q_low);
      rem_r   <= DIV_W'(q_high) * DIV_W'(DUTY_SCALE);
      quot_r  <= '0;
      cnt_r   <= CNT_W'(QUOT_BITS - 1);
    end else if (state_r == ST_DIV) begin
      if (fits) begin
        rem_r <= rem_r - divisor_sh;
      end
      quot_r <= {quot_r[QUOT_BITS-2:0], fits};
      cnt_r  <= cnt_r - 1'b1;
    end
  end

  assign out_valid             = (state_r == ST_OUT);
  assign out_high_time         = DUR_W'(high_r);
  assign out_low_time          = DUR_W'(low_r);
  assign out_total_period      = TOTAL_W'(total_r);
  assign out_duty_valid        = (total_r != '0);
  // zero period: divider output is meaningless, force duty to zero
  assign out_duty_percent      = out_duty_valid ? quot_r : '0;
  assign out_edge_was_falling  = flags_r.was_falling;
  assign out_next_edge_falling = flags_r.next_falling;

endmodule

// ===== rtl/core/pwm_capture_duty_meter.sv =====
// pwm_capture_duty_meter: top level of the PWM period and duty meter.
// Instantiates pcdm_front, pcdm_queue and pcdm_back; depends on pcdm_pkg.
//
//   channel  direction  handshake            payload
//   in_      request in  in_valid / in_stall  in_edge_timestamp
//   out_     result out  out_valid/out_stall  high, low, total, duty, flags
//   cfg_     write       cfg_wr_en            cfg_wr_data (starting edge)
//
// Flow: an edge request enters the queue in the cycle it is accepted; the back
// end loads it from the queue head, runs the divider loop (one duty bit a cycle)
// and holds the result until it is taken, and only then pops the next request.
// Reset: synchronous, active low; polarity arms to rising, timestamp and durations
// clear. Stalls: in_stall rises only when the two-entry queue is full; out_stall
// holds the result register and the back end, while the front keeps accepting until the queue fills.
module pwm_capture_duty_meter #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // configuration
  input  logic                         cfg_wr_en,
  input  logic                         cfg_wr_data,
  // edge requests
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [pcdm_pkg::STAMP_W-1:0] in_edge_timestamp,
  // results
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [pcdm_pkg::DUR_W-1:0]   out_high_time,
  output logic [pcdm_pkg::DUR_W-1:0]   out_low_time,
  output logic [pcdm_pkg::TOTAL_W-1:0] out_total_period,
  output logic [pcdm_pkg::DUTY_W-1:0]  out_duty_percent,
  output logic                         out_duty_valid,
  output logic                         out_edge_was_falling,
  output logic                         out_next_edge_falling
);
  import pcdm_pkg::*;

  // queue entry: high duration, low duration, polarity flags
  localparam int FLAGS_W = $bits(pcdm_flags_t);
  localparam int ENTRY_W = 2 * TIMER_WIDTH + FLAGS_W;

  logic                   accept;
  logic [TIMER_WIDTH-1:0] f_high;
  logic [TIMER_WIDTH-1:0] f_low;
  pcdm_flags_t            f_flags;
  logic                   q_full;
  logic                   q_pop;
  logic                   q_not_empty;
  logic [ENTRY_W-1:0]     q_entry;
  logic [TIMER_WIDTH-1:0] q_high;
  logic [TIMER_WIDTH-1:0] q_low;
  pcdm_flags_t            q_flags;

  // stall new edges only while the queue has no room
  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  pcdm_front #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .accept     (accept),
    .stamp_in   (in_edge_timestamp),
    .high_nxt   (f_high),
    .low_nxt    (f_low),
    .flags      (f_flags)
  );

  pcdm_queue #(
    .WIDTH(ENTRY_W)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (accept),
    .push_data({f_high, f_low, f_flags}),
    .full     (q_full),
    .pop      (q_pop),
    .pop_data (q_entry),
    .not_empty(q_not_empty)
  );

  // unpack the queue head
  assign q_high  = q_entry[ENTRY_W-1 -: TIMER_WIDTH];
  assign q_low   = q_entry[FLAGS_W +: TIMER_WIDTH];
  assign q_flags = q_entry[FLAGS_W-1:0];

  pcdm_back #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_not_empty          (q_not_empty),
    .q_high               (q_high),
    .q_low                (q_low),
    .q_flags              (q_flags),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_high_time        (out_high_time),
    .out_low_time         (out_low_time),
    .out_total_period     (out_total_period),
    .out_duty_percent     (out_duty_percent),
    .out_duty_valid       (out_duty_valid),
    .out_edge_was_falling (out_edge_was_falling),
    .out_next_edge_falling(out_next_edge_falling)
  );

endmodule

// ===== rtl/core/pcdm_checker.sv =====
// pcdm_checker: port-level assertions for pwm_capture_duty_meter, plus the bind
// that attaches them. Depends only on the top level's ports.
module pcdm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_wr_en,
  input logic        cfg_wr_data,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] in_edge_timestamp,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_high_time,
  input logic [15:0] out_low_time,
  input logic [16:0] out_total_period,
  input logic [6:0]  out_duty_percent,
  input logic        out_duty_valid,
  input logic        out_edge_was_falling,
  input logic        out_next_edge_falling
);

  // a stalled result stays up and unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_duty_percent)
      && $stable(out_high_time) && $stable(out_low_time))
    else $error("result changed while stalled");

  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_duty_percent <= 7'd100)
    else $error("duty above 100 percent");

  a_zero_period: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_duty_valid |-> out_duty_percent == 7'd0)
    else $error("duty not forced to zero on invalid period");

  a_polarity_flip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_next_edge_falling != out_edge_was_falling)
    else $error("armed polarity does not alternate");

endmodule

bind pwm_capture_duty_meter pcdm_checker u_pcdm_checker (.*);
